FILE: hdl/eucl_pkg.sv
`default_nettype none
package eucl_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W = 6;
	localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int COORD_W = 7;
	localparam int FRAC_W = 8;
	localparam int LEN_W = 22;
	localparam int FIT_W = 25;

	// Sum of two squared coordinate differences, then scaled up to Q8.8 squared.
	localparam int SQ_W = 2 * COORD_W + 1;
	localparam int RAD_W = SQ_W + 2 * FRAC_W + (SQ_W % 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int SQ_CNT_W = $clog2(ROOT_W);
	localparam int DIV_CNT_W = $clog2(FIT_W);

	localparam logic [LEN_W-1:0] SUM_MAX = {LEN_W{1'b1}};
	localparam logic [FIT_W-1:0] FIT_SAT = FIT_W'(1) << (FIT_W - 1);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_ROUTE = 1'b1;

	typedef struct packed {
		logic                func;
		logic [NODE_W-1:0]   node;
		logic [COORD_W-1:0]  coord_x;
		logic [COORD_W-1:0]  coord_y;
		logic                last;
	} route_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] tour_length;
		logic [FIT_W-1:0] fitness;
		logic             zero_length;
	} result_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage
`default_nettype wire

FILE: hdl/eucl_if.sv
`default_nettype none
interface eucl_route_if
	import eucl_pkg::*;
	;
	logic        valid;
	logic        ready;
	route_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface eucl_result_if
	import eucl_pkg::*;
	;
	logic         valid;
	logic         ready;
	result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/eucl_sqrt.sv
`default_nettype none
module eucl_sqrt
	import eucl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [RAD_W-1:0]  radicand,
	output unit_stat_t             stat,
	output logic [ROOT_W-1:0]      root
);

	logic [RAD_W-1:0]    rem_q;
	logic [RAD_W-1:0]    root_q;
	logic [RAD_W-1:0]    bit_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [RAD_W-1:0]    trial;
	logic                take;

	assign trial = root_q + bit_q;
	assign take = rem_q >= trial;

	// One result bit per cycle; bit_q walks down the even powers of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= SQ_CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			root_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign root = root_q[ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/eucl_div.sv
`default_nettype none
module eucl_div
	import eucl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [LEN_W-1:0]  divisor,
	output unit_stat_t             stat,
	output logic [FIT_W-1:0]       quotient
);

	logic [LEN_W-1:0]     div_q;
	logic [LEN_W-1:0]     rem_q;
	logic [FIT_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [LEN_W:0]       rem_sh;
	logic                 take;

	// Restoring division of the constant FIT_SAT, one quotient bit per cycle.
	assign rem_sh = {rem_q, FIT_SAT[cnt_q]};
	assign take = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(FIT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= LEN_W'(rem_sh - {1'b0, div_q});
			end else begin
				rem_q <= rem_sh[LEN_W-1:0];
			end
			quo_q <= {quo_q[FIT_W-2:0], take};
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: hdl/euclidean_tour_length_top.sv
// Channel  Role   Beat contents
// route    sink   func, node, coord_x, coord_y, last
// result   source tour_length (Q14.8), fitness (Q9.16), zero_length
//
// A node write is stored on acceptance. An edge after the beat takes two memory reads,
// squares, a start state, 16 square root steps and the accumulate. The closing item of a
// longer route adds an edge, reciprocal division if the sum is nonzero, and a result load.
// arst_n clears the route state; the coordinate memory keeps no reset.
// A result waiting on the output register holds off only the next closing item.
`default_nettype none
module euclidean_tour_length_top
	import eucl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	eucl_route_if.sink   route,
	eucl_result_if.source result
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD_A = 4'd1;
	localparam logic [3:0] S_RD_B = 4'd2;
	localparam logic [3:0] S_SQ   = 4'd3;
	localparam logic [3:0] S_SQS  = 4'd4;
	localparam logic [3:0] S_SQW  = 4'd5;
	localparam logic [3:0] S_DIVS = 4'd6;
	localparam logic [3:0] S_DIVW = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0]           state_q;
	logic [NODE_W-1:0]    first_q;
	logic [NODE_W-1:0]    prev_q;
	logic [NODE_W-1:0]    node_q;
	logic [NODE_W-1:0]    a_q;
	logic [NODE_W-1:0]    b_q;
	logic                 last_q;
	logic                 closing_q;
	logic                 in_route_q;
	logic [LEN_W-1:0]     sum_q;
	logic [COORD_W-1:0]   ax_q;
	logic [COORD_W-1:0]   ay_q;
	logic [2*COORD_W-1:0] sqx_q;
	logic [2*COORD_W-1:0] sqy_q;
	logic                 out_valid_q;
	result_item_t         out_q;

	logic [2*COORD_W-1:0] coord_mem [MAX_NODES];
	logic [2*COORD_W-1:0] rd_data_q;
	logic                 rd_ok_q;
	logic [NODE_W-1:0]    rd_node;
	logic                 wr_en;

	logic                 accept;
	logic [COORD_W-1:0]   bx;
	logic [COORD_W-1:0]   by;
	logic [COORD_W-1:0]   dx;
	logic [COORD_W-1:0]   dy;
	logic [RAD_W-1:0]     radicand;
	logic [LEN_W:0]       sum_ext;
	logic [LEN_W-1:0]     sum_sat;
	logic                 out_free;

	unit_stat_t           sq_stat;
	unit_stat_t           div_stat;
	logic [ROOT_W-1:0]    edge_len;
	logic [FIT_W-1:0]     quotient;

	assign route.ready = (state_q == S_IDLE);
	assign accept = route.valid && route.ready;
	assign wr_en = accept && (route.data.func == FUNC_WRITE)
		&& (32'(route.data.node) < MAX_NODES);
	assign rd_node = (state_q == S_RD_A) ? a_q : b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coord_mem[ADDR_W'(route.data.node)] <= {route.data.coord_x, route.data.coord_y};
		end
		rd_data_q <= coord_mem[ADDR_W'(rd_node)];
		rd_ok_q <= 32'(rd_node) < MAX_NODES;
	end

	// Nodes beyond the store read as the origin.
	assign bx = rd_ok_q ? rd_data_q[2*COORD_W-1:COORD_W] : '0;
	assign by = rd_ok_q ? rd_data_q[COORD_W-1:0] : '0;
	assign dx = (ax_q > bx) ? ax_q - bx : bx - ax_q;
	assign dy = (ay_q > by) ? ay_q - by : by - ay_q;
	assign radicand = RAD_W'({SQ_W'(sqx_q) + SQ_W'(sqy_q), {(2*FRAC_W){1'b0}}});
	assign sum_ext = {1'b0, sum_q} + (LEN_W+1)'(edge_len);
	assign sum_sat = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[LEN_W-1:0];
	assign out_free = !out_valid_q || result.ready;

	eucl_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SQS),
		.radicand (radicand),
		.stat     (sq_stat),
		.root     (edge_len)
	);

	eucl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIVS),
		.divisor  (sum_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= '0;
			prev_q <= '0;
			sum_q <= '0;
			in_route_q <= 1'b0;
			closing_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && route.data.func == FUNC_ROUTE) begin
						last_q <= route.data.last;
						closing_q <= 1'b0;
						prev_q <= route.data.node;
						if (!in_route_q) begin
							first_q <= route.data.node;
							sum_q <= '0;
							// A route of one node closes on itself with zero length.
							in_route_q <= !route.data.last;
							if (route.data.last) begin
								state_q <= S_FIN;
							end
						end else begin
							state_q <= S_RD_A;
						end
					end
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: state_q <= S_SQ;
				S_SQ: state_q <= S_SQS;
				S_SQS: state_q <= S_SQW;
				S_SQW: begin
					if (sq_stat.done) begin
						sum_q <= sum_sat;
						if (closing_q) begin
							in_route_q <= 1'b0;
							state_q <= (sum_sat == '0) ? S_FIN : S_DIVS;
						end else if (last_q) begin
							closing_q <= 1'b1;
							state_q <= S_RD_A;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DIVS: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && route.data.func == FUNC_ROUTE) begin
			node_q <= route.data.node;
			a_q <= prev_q;
			b_q <= route.data.node;
		end
		if (state_q == S_SQW && sq_stat.done && !closing_q && last_q) begin
			a_q <= node_q;
			b_q <= first_q;
		end
		if (state_q == S_RD_B) begin
			ax_q <= bx;
			ay_q <= by;
		end
		if (state_q == S_SQ) begin
			sqx_q <= dx * dx;
			sqy_q <= dy * dy;
		end
		if (state_q == S_FIN && out_free) begin
			out_q.tour_length <= sum_q;
			out_q.zero_length <= (sum_q == '0);
			out_q.fitness <= (sum_q == '0) ? FIT_SAT : quotient;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = out_q;

endmodule
`default_nettype wire

FILE: hdl/eucl_checker.sv
`default_nettype none
module eucl_checker
	import eucl_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire logic [LEN_W-1:0] tour_length,
	input wire logic [FIT_W-1:0] fitness,
	input wire logic             zero_length
);

	logic [2*FIT_W-1:0] prod;
	assign prod = (2*FIT_W)'(fitness) * (2*FIT_W)'(tour_length);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(tour_length) && $stable(fitness))
		else $error("result beat changed while stalled");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (zero_length == (tour_length == '0)))
		else $error("zero_length disagrees with tour_length");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && zero_length |-> fitness == FIT_SAT)
		else $error("fitness not saturated for zero length");

	a_recip: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !zero_length |-> prod <= (2*FIT_W)'(FIT_SAT)
			&& prod + (2*FIT_W)'(tour_length) > (2*FIT_W)'(FIT_SAT))
		else $error("fitness is not the floored reciprocal");

endmodule

bind euclidean_tour_length_top eucl_checker u_eucl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.tour_length (result.data.tour_length),
	.fitness     (result.data.fitness),
	.zero_length (result.data.zero_length)
);
`default_nettype wire

FILE: tb/tb_euclidean_tour_length_top.sv
module tb_euclidean_tour_length_top;
	timeunit 1ns;
	timeprecision 1ps;
	import eucl_pkg::*;

	typedef struct {
		route_item_t beat;
		bit          drain;
	} route_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	eucl_route_if  route_ch();
	eucl_result_if result_ch();

	euclidean_tour_length_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.route  (route_ch),
		.result (result_ch)
	);

	route_entry_t route_backlog[$];
	result_item_t tour_totals[$];

	logic [COORD_W-1:0] x_mem[MAX_NODES];
	logic [COORD_W-1:0] y_mem[MAX_NODES];
	logic [NODE_W-1:0]  tour_first = '0;
	logic [NODE_W-1:0]  tour_prev = '0;
	logic [LEN_W-1:0]   len_acc = '0;
	bit                 tour_open = 1'b0;
	bit [MAX_NODES-1:0] node_written = '0;

	int mismatches = 0;
	int results_due = 0;
	int results_got = 0;
	int beats_sent = 0;
	int hold_left = 0;
	bit held = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic [15:0] root_floor(input logic [31:0] rad);
		logic [15:0] root;
		logic [15:0] trial;
		root = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = root | (16'd1 << b);
			if (32'(trial) * 32'(trial) <= rad)
				root = trial;
		end
		return root;
	endfunction

	// Edge length in Q8.8, rounded down.
	function automatic logic [LEN_W-1:0] edge_q88(input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [31:0]        rad;
		dx = (x_mem[a] > x_mem[b]) ? x_mem[a] - x_mem[b] : x_mem[b] - x_mem[a];
		dy = (y_mem[a] > y_mem[b]) ? y_mem[a] - y_mem[b] : y_mem[b] - y_mem[a];
		rad = ((32'(dx) * 32'(dx)) + (32'(dy) * 32'(dy))) << 16;
		return LEN_W'(root_floor(rad));
	endfunction

	function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] s,
			input logic [LEN_W-1:0] d);
		logic [LEN_W:0] t;
		t = {1'b0, s} + {1'b0, d};
		return t[LEN_W] ? SUM_MAX : t[LEN_W-1:0];
	endfunction

	task automatic advance_tour(input route_item_t it);
		result_item_t res;
		if (it.func == FUNC_WRITE) begin
			x_mem[it.node] = it.coord_x;
			y_mem[it.node] = it.coord_y;
		end else begin
			if (!tour_open) begin
				tour_first = it.node;
				tour_prev = it.node;
				len_acc = '0;
				tour_open = 1'b1;
			end else begin
				len_acc = sat_add(len_acc, edge_q88(tour_prev, it.node));
				tour_prev = it.node;
			end
			if (it.last) begin
				len_acc = sat_add(len_acc, edge_q88(it.node, tour_first));
				tour_open = 1'b0;
				res.tour_length = len_acc;
				res.zero_length = (len_acc == '0);
				res.fitness = (len_acc == '0) ? FIT_SAT
					: FIT_W'(64'(FIT_SAT) / 64'(len_acc));
				tour_totals.insert(tour_totals.size(), res);
				results_due++;
			end
		end
	endtask

	task automatic check_tour(input result_item_t got);
		result_item_t want;
		if (tour_totals.size() == 0) begin
			flag_mismatch($sformatf("unexpected result beat, length %0d", got.tour_length));
		end else begin
			want = tour_totals.pop_front();
			if (got.tour_length !== want.tour_length)
				flag_mismatch($sformatf("tour_length got %0d want %0d",
					got.tour_length, want.tour_length));
			if (got.fitness !== want.fitness)
				flag_mismatch($sformatf("fitness got %0d want %0d (length %0d)",
					got.fitness, want.fitness, want.tour_length));
			if (got.zero_length !== want.zero_length)
				flag_mismatch($sformatf("zero_length got %0b want %0b",
					got.zero_length, want.zero_length));
		end
	endtask

	function automatic int rand_coord();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return $urandom_range(127, 101);
		if (r == 1)
			return ($urandom_range(1) == 0) ? 0 : 127;
		return $urandom_range(100);
	endfunction

	task automatic queue_write(input int n, input int cx, input int cy);
		route_entry_t e;
		e.beat.func = FUNC_WRITE;
		e.beat.node = NODE_W'(n);
		e.beat.coord_x = COORD_W'(cx);
		e.beat.coord_y = COORD_W'(cy);
		e.beat.last = 1'($urandom_range(1));
		e.drain = 1'b0;
		route_backlog.insert(route_backlog.size(), e);
		node_written[n] = 1'b1;
	endtask

	task automatic queue_visit(input int n, input bit last);
		route_entry_t e;
		e.beat.func = FUNC_ROUTE;
		e.beat.node = NODE_W'(n);
		e.beat.coord_x = COORD_W'($urandom_range(127));
		e.beat.coord_y = COORD_W'($urandom_range(127));
		e.beat.last = last;
		e.drain = 1'b0;
		route_backlog.insert(route_backlog.size(), e);
	endtask

	// Tours only visit nodes whose coordinates have been written.
	function automatic int any_written();
		int n;
		do
			n = $urandom_range(MAX_NODES - 1);
		while (!node_written[n]);
		return n;
	endfunction

	// Route sender.
	always @(posedge clk or negedge arst_n) begin
		bit may_idle;
		if (!arst_n) begin
			route_ch.valid <= 1'b0;
			route_ch.data <= '0;
		end else begin
			if (route_ch.valid && route_ch.ready) begin
				advance_tour(route_ch.data);
				beats_sent++;
			end
			if (!route_ch.valid || route_ch.ready) begin
				may_idle = (beats_sent < 300 || beats_sent >= 550) && $urandom_range(99) < 12;
				if (route_backlog.size() != 0 && !may_idle
						&& !(route_backlog[0].drain && results_got != results_due)) begin
					route_ch.valid <= 1'b1;
					route_ch.data <= route_backlog[0].beat;
					void'(route_backlog.pop_front());
				end else begin
					route_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver; once it holds ready low long enough for closing items to back up.
	always @(posedge clk or negedge arst_n) begin
		bit may_idle;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			results_got <= 0;
			hold_left <= 0;
			held <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				check_tour(result_ch.data);
				results_got <= results_got + 1;
			end
			may_idle = (results_got < 20 || results_got >= 45) && $urandom_range(99) < 12;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else if (!held && results_got == 12) begin
				held <= 1'b1;
				hold_left <= 1500;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !may_idle;
			end
		end
	end

	initial begin
		int pick;
		int hops;
		bit sat_done;

		route_ch.valid = 1'b0;
		route_ch.data = '0;
		result_ch.ready = 1'b0;
		sat_done = 1'b0;

		queue_write(0, 0, 0);
		queue_write(63, 127, 127);
		queue_write(1, 100, 100);
		queue_write(2, 0, 127);
		queue_write(3, 127, 0);
		// A tour of one node closes on itself with zero length.
		queue_visit(63, 1'b1);
		queue_visit(0, 1'b0);
		queue_visit(63, 1'b1);
		queue_visit(0, 1'b0);
		queue_visit(1, 1'b0);
		queue_visit(2, 1'b0);
		queue_visit(3, 1'b1);
		queue_visit(2, 1'b0);
		queue_visit(2, 1'b1);
		// Moving a node in the middle of a tour affects only later edges.
		queue_visit(1, 1'b0);
		queue_write(1, 85, 42);
		queue_visit(2, 1'b0);
		queue_visit(1, 1'b1);

		while (route_backlog.size() < 1100) begin
			if (!sat_done && route_backlog.size() >= 550) begin
				// Long zigzag between opposite corners drives the sum into saturation.
				queue_write(61, 0, 0);
				queue_write(62, 127, 127);
				for (int k = 0; k < 100; k++)
					queue_visit((k % 2 == 0) ? 61 : 62, k == 99);
				sat_done = 1'b1;
			end else begin
				pick = $urandom_range(99);
				if (pick < 15) begin
					repeat ($urandom_range(4, 1))
						queue_write($urandom_range(MAX_NODES - 1), rand_coord(), rand_coord());
				end else if (pick < 95) begin
					hops = ($urandom_range(9) == 0) ? $urandom_range(30, 13)
						: $urandom_range(12, 1);
					for (int k = 0; k < hops; k++) begin
						if ($urandom_range(9) == 0)
							queue_write($urandom_range(MAX_NODES - 1), rand_coord(),
								rand_coord());
						queue_visit(any_written(), k == hops - 1);
					end
				end else begin
					queue_write($urandom_range(MAX_NODES - 1), $urandom_range(1) * 127,
						$urandom_range(1) * 127);
				end
			end
		end
		route_backlog[300].drain = 1'b1;
		route_backlog[820].drain = 1'b1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (route_backlog.size() != 0 || route_ch.valid)
			@(posedge clk);
		while (results_got != results_due)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (tour_totals.size() != 0)
			flag_mismatch($sformatf("%0d tour results never arrived", tour_totals.size()));
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
